// ----- rtl/core/sector_scan_coordinate_generator_defines.svh -----
// ----------------------------------------------------------------------------
// sector scan coordinate generator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef SECTOR_SCAN_COORDINATE_GENERATOR_DEFINES_SVH
`define SECTOR_SCAN_COORDINATE_GENERATOR_DEFINES_SVH

// checked only out of reset
`define SSC_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// checked at every edge, reset included
`define SSC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- rtl/core/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// types, register codes and constants of the sector scan coordinate generator
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int RAD_W        = 10;
    localparam int SPAN_W       = 16;
    localparam int COORD_W      = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int ANG_SHIFT    = 8;
    localparam int RQ_W         = 20;
    localparam int ANG_W        = 26;
    localparam int CV_W         = 33;
    localparam int CORDIC_STEPS = 16;
    localparam int RQ_QBITS     = RAD_W + FRAC_BITS;
    localparam int ANG_QBITS    = SPAN_W + ANG_SHIFT;
    localparam int DIV_STAGES   = ANG_QBITS;
    localparam int RAD_SKIP     = DIV_STAGES - RQ_QBITS;
    localparam int PROD_W       = RQ_W + CV_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAD_LO     = 3'd0,
        REG_RAD_HI     = 3'd1,
        REG_ANGLE_SPAN = 3'd2,
        REG_ROW_COUNT  = 3'd3,
        REG_COL_COUNT  = 3'd4
    } ssc_reg_t;

    localparam logic [RAD_W-1:0]  RST_RAD_LO     = 10'd1;
    localparam logic [RAD_W-1:0]  RST_RAD_HI     = 10'd300;
    localparam logic [SPAN_W-1:0] RST_ANGLE_SPAN = 16'd14080;
    localparam logic [CNT_W-1:0]  RST_ROW_COUNT  = 13'd256;
    localparam logic [CNT_W-1:0]  RST_COL_COUNT  = 13'd256;

    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd5898240;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 26'sd11796480;
    localparam logic signed [CV_W-1:0]  CORDIC_GAIN  = 33'sd652032874;
    localparam logic signed [PROD_W-1:0] ROUND_HALF  = 53'sd536870912;
    localparam logic signed [24:0] COORD_MAX = 25'sd524287;
    localparam logic signed [24:0] COORD_MIN = -25'sd524288;

    localparam logic signed [ANG_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115
    };

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
    } ssc_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      index_error;
    } ssc_result_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad_lo;
        logic [RAD_W-1:0]  rad_hi;
        logic [SPAN_W-1:0] angle_span;
        logic [CNT_W-1:0]  row_count;
        logic [CNT_W-1:0]  col_count;
    } ssc_cfg_t;

    typedef struct packed {
        logic                   err;
        logic signed [RQ_W-1:0] rq;
    } ssc_side_t;

endpackage

// ----- rtl/core/ssc_front.sv -----
// ----------------------------------------------------------------------------
// ssc_front
// index check, radius and angle products and two pipelined long dividers
// ----------------------------------------------------------------------------
module ssc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_v,
    input  ssc_pkg::ssc_item_t                item,
    input  ssc_pkg::ssc_cfg_t                 cfg,
    output logic                              out_v,
    output logic                              out_err,
    output logic signed [ssc_pkg::RQ_W-1:0]   out_rq,
    output logic signed [ssc_pkg::ANG_W-1:0]  out_ang
);
    import ssc_pkg::*;

    localparam int AP_W = IDX_W + SPAN_W;
    localparam int RP_W = IDX_W + RAD_W;

    logic signed [RAD_W:0] diff;
    logic [RAD_W-1:0]      mag;
    logic [RP_W-1:0]       rprod;
    logic [AP_W-1:0]       aprod;
    logic                  err_next;

    logic                 v_reg   [0:DIV_STAGES];
    logic                 err_reg [0:DIV_STAGES];
    logic [CNT_W-1:0]     ar_reg  [0:DIV_STAGES];
    logic [ANG_QBITS-1:0] aw_reg  [0:DIV_STAGES];
    logic [CNT_W-1:0]     rr_reg  [0:DIV_STAGES];
    logic [RQ_QBITS-1:0]  rw_reg  [0:DIV_STAGES];

    logic                   fv_reg;
    logic                   ferr_reg;
    logic signed [RQ_W-1:0] rq_reg;
    logic signed [RQ_W-1:0] rq_next;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [ANG_W-1:0] ang_next;

    always_comb
    begin
        diff     = $signed({1'b0, cfg.rad_hi}) - $signed({1'b0, cfg.rad_lo});
        mag      = diff[RAD_W] ? RAD_W'(-diff) : diff[RAD_W-1:0];
        rprod    = RP_W'(item.row_index) * RP_W'(mag);
        aprod    = AP_W'(item.col_index) * AP_W'(cfg.angle_span);
        err_next = ({1'b0, item.row_index} >= cfg.row_count) ||
                   ({1'b0, item.col_index} >= cfg.col_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_v;
        end
    end

    // top bits of the numerator start as the remainder, which stays below the count
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg[0] <= err_next;
            ar_reg[0]  <= CNT_W'(aprod[AP_W-1:ANG_QBITS-ANG_SHIFT]);
            aw_reg[0]  <= {aprod[ANG_QBITS-ANG_SHIFT-1:0], {ANG_SHIFT{1'b0}}};
            rr_reg[0]  <= CNT_W'(rprod[RP_W-1:RQ_QBITS-FRAC_BITS]);
            rw_reg[0]  <= {rprod[RQ_QBITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [CNT_W:0]       a_trial;
        logic                 a_ge;
        logic [CNT_W-1:0]     ar_next;
        logic [ANG_QBITS-1:0] aw_next;
        logic [CNT_W-1:0]     rr_next;
        logic [RQ_QBITS-1:0]  rw_next;

        always_comb
        begin
            a_trial = {ar_reg[k], aw_reg[k][ANG_QBITS-1]};
            a_ge    = a_trial >= {1'b0, cfg.col_count};
            ar_next = a_ge ? CNT_W'(a_trial - {1'b0, cfg.col_count}) : a_trial[CNT_W-1:0];
            aw_next = {aw_reg[k][ANG_QBITS-2:0], a_ge};
        end

        if (k >= RAD_SKIP)
        begin : g_rad
            logic [CNT_W:0] r_trial;
            logic           r_ge;

            always_comb
            begin
                r_trial = {rr_reg[k], rw_reg[k][RQ_QBITS-1]};
                r_ge    = r_trial >= {1'b0, cfg.row_count};
                rr_next = r_ge ? CNT_W'(r_trial - {1'b0, cfg.row_count})
                               : r_trial[CNT_W-1:0];
                rw_next = {rw_reg[k][RQ_QBITS-2:0], r_ge};
            end
        end
        else
        begin : g_wait
            // radius quotient is shorter, so it idles in the first stages
            always_comb
            begin
                rr_next = rr_reg[k];
                rw_next = rw_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                err_reg[k+1] <= err_reg[k];
                ar_reg[k+1]  <= ar_next;
                aw_reg[k+1]  <= aw_next;
                rr_reg[k+1]  <= rr_next;
                rw_reg[k+1]  <= rw_next;
            end
        end
    end

    always_comb
    begin
        rq_next = diff[RAD_W]
            ? $signed({2'b0, cfg.rad_lo, {FRAC_BITS{1'b0}}}) -
              $signed({2'b0, rw_reg[DIV_STAGES]})
            : $signed({2'b0, cfg.rad_lo, {FRAC_BITS{1'b0}}}) +
              $signed({2'b0, rw_reg[DIV_STAGES]});
        ang_next = $signed({2'b0, aw_reg[DIV_STAGES]}) -
                   $signed({3'b0, cfg.angle_span, 7'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (adv)
        begin
            fv_reg <= v_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ferr_reg <= err_reg[DIV_STAGES];
            rq_reg   <= rq_next;
            ang_reg  <= ang_next;
        end
    end

    assign out_v   = fv_reg;
    assign out_err = ferr_reg;
    assign out_rq  = rq_reg;
    assign out_ang = ang_reg;

endmodule

// ----- rtl/core/ssc_cordic.sv -----
// ----------------------------------------------------------------------------
// ssc_cordic
// quadrant fold and sixteen stage rotation-mode cordic in degrees
// ----------------------------------------------------------------------------
module ssc_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_v,
    input  logic signed [ssc_pkg::ANG_W-1:0]  ang,
    input  ssc_pkg::ssc_side_t                side,
    output logic                              out_v,
    output logic signed [ssc_pkg::CV_W-1:0]   cosv,
    output logic signed [ssc_pkg::CV_W-1:0]   sinv,
    output ssc_pkg::ssc_side_t                out_side
);
    import ssc_pkg::*;

    logic signed [ANG_W-1:0] z_next;
    logic                    flip_next;

    logic                    v_reg    [0:CORDIC_STEPS];
    logic                    flip_reg [0:CORDIC_STEPS];
    ssc_side_t               side_reg [0:CORDIC_STEPS];
    logic signed [CV_W-1:0]  x_reg    [0:CORDIC_STEPS];
    logic signed [CV_W-1:0]  y_reg    [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg    [0:CORDIC_STEPS];

    logic                   ov_reg;
    logic signed [CV_W-1:0] cos_reg;
    logic signed [CV_W-1:0] sin_reg;
    ssc_side_t              oside_reg;

    // fold into +-90 degrees, results negated afterwards
    always_comb
    begin
        z_next    = ang;
        flip_next = 1'b0;
        if (ang > QUARTER_TURN)
        begin
            z_next    = ang - HALF_TURN;
            flip_next = 1'b1;
        end
        else if (ang < -QUARTER_TURN)
        begin
            z_next    = ang + HALF_TURN;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flip_reg[0] <= flip_next;
            side_reg[0] <= side;
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CV_W-1:0]  x_next;
        logic signed [CV_W-1:0]  y_next;
        logic signed [ANG_W-1:0] zs_next;

        always_comb
        begin
            if (!z_reg[i][ANG_W-1])
            begin
                x_next  = x_reg[i] - (y_reg[i] >>> i);
                y_next  = y_reg[i] + (x_reg[i] >>> i);
                zs_next = z_reg[i] - ATAN_DEG[i];
            end
            else
            begin
                x_next  = x_reg[i] + (y_reg[i] >>> i);
                y_next  = y_reg[i] - (x_reg[i] >>> i);
                zs_next = z_reg[i] + ATAN_DEG[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                flip_reg[i+1] <= flip_reg[i];
                side_reg[i+1] <= side_reg[i];
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= zs_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg   <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg   <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
            oside_reg <= side_reg[CORDIC_STEPS];
        end
    end

    assign out_v    = ov_reg;
    assign cosv     = cos_reg;
    assign sinv     = sin_reg;
    assign out_side = oside_reg;

endmodule

// ----- rtl/core/ssc_project.sv -----
// ----------------------------------------------------------------------------
// ssc_project
// radius times cos and sin, rounding, offset and saturation
// ----------------------------------------------------------------------------
module ssc_project (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_v,
    input  logic signed [ssc_pkg::CV_W-1:0]  cosv,
    input  logic signed [ssc_pkg::CV_W-1:0]  sinv,
    input  ssc_pkg::ssc_side_t               side,
    input  logic [ssc_pkg::RAD_W-1:0]        rad_lo,
    output logic                             out_v,
    output ssc_pkg::ssc_result_t             out_res
);
    import ssc_pkg::*;

    localparam int T_W = PROD_W - 30;

    logic                     mv_reg;
    logic                     merr_reg;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;

    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;
    logic signed [PROD_W-1:0] xs;
    logic signed [PROD_W-1:0] ys;
    logic signed [24:0]       base;
    logic signed [24:0]       xv;
    logic signed [24:0]       yv;
    ssc_result_t              res_next;

    logic                     ov_reg;
    ssc_result_t              res_reg;

    function automatic logic signed [COORD_W-1:0] clamp(input logic signed [24:0] v);
        logic signed [COORD_W-1:0] c;
        if (v > COORD_MAX)
            c = COORD_MAX[COORD_W-1:0];
        else if (v < COORD_MIN)
            c = COORD_MIN[COORD_W-1:0];
        else
            c = v[COORD_W-1:0];
        return c;
    endfunction

    always_comb
    begin
        px_next = PROD_W'(side.rq) * PROD_W'(cosv);
        py_next = PROD_W'(side.rq) * PROD_W'(sinv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            mv_reg <= in_v;
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            merr_reg <= side.err;
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
    end

    // round half up to the coordinate grid, floor shift
    always_comb
    begin
        xs   = (px_reg + ROUND_HALF) >>> 30;
        ys   = (py_reg + ROUND_HALF) >>> 30;
        base = $signed({7'b0, rad_lo, {FRAC_BITS{1'b0}}});
        xv   = -25'($signed(xs[T_W-1:0])) - base;
        yv   = -25'($signed(ys[T_W-1:0])) - base;
        if (merr_reg)
        begin
            res_next.x_coord = '0;
            res_next.y_coord = '0;
        end
        else
        begin
            res_next.x_coord = clamp(xv);
            res_next.y_coord = clamp(yv);
        end
        res_next.index_error = merr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_v   = ov_reg;
    assign out_res = res_reg;

endmodule

// ----- rtl/core/sector_scan_coordinate_generator.sv -----
// ----------------------------------------------------------------------------
// sector_scan_coordinate_generator
// polar to cartesian scan conversion of sector image indices
// ----------------------------------------------------------------------------
// Takes one (row, column) index pair per clock and returns one x/y display
// coordinate pair per clock, in order, while results are taken and the skid
// stage is empty, via two long dividers at one quotient bit per stage (24
// stages), a 16 stage cordic and a multiply stage. An output register with a
// skid stage keeps input open while one result waits. The user must write
// configuration only while no item is in flight; it is not enforced.
module sector_scan_coordinate_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ssc_pkg::ssc_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ssc_pkg::ssc_result_t                result,
    input  logic                                cfg_we,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ssc_pkg::*;

    ssc_cfg_t cfg_reg;

    logic                    adv;
    logic                    f_v;
    logic                    f_err;
    logic signed [RQ_W-1:0]  f_rq;
    logic signed [ANG_W-1:0] f_ang;
    ssc_side_t               f_side;
    logic                    c_v;
    logic signed [CV_W-1:0]  c_cos;
    logic signed [CV_W-1:0]  c_sin;
    ssc_side_t               c_side;
    logic                    p_v;
    ssc_result_t             p_res;

    logic        out_v_reg;
    ssc_result_t out_reg;
    logic        skid_v_reg;
    ssc_result_t skid_reg;
    logic        load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rad_lo     <= RST_RAD_LO;
            cfg_reg.rad_hi     <= RST_RAD_HI;
            cfg_reg.angle_span <= RST_ANGLE_SPAN;
            cfg_reg.row_count  <= RST_ROW_COUNT;
            cfg_reg.col_count  <= RST_COL_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RAD_LO:     cfg_reg.rad_lo     <= cfg_data[RAD_W-1:0];
                REG_RAD_HI:     cfg_reg.rad_hi     <= cfg_data[RAD_W-1:0];
                REG_ANGLE_SPAN: cfg_reg.angle_span <= cfg_data[SPAN_W-1:0];
                REG_ROW_COUNT:  cfg_reg.row_count  <= cfg_data[CNT_W-1:0];
                REG_COL_COUNT:  cfg_reg.col_count  <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // whole pipeline moves together unless the skid stage is holding a result
    assign adv        = !skid_v_reg;
    assign item_ready = adv;

    ssc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (item_valid),
        .item    (item),
        .cfg     (cfg_reg),
        .out_v   (f_v),
        .out_err (f_err),
        .out_rq  (f_rq),
        .out_ang (f_ang)
    );

    assign f_side.err = f_err;
    assign f_side.rq  = f_rq;

    ssc_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_v     (f_v),
        .ang      (f_ang),
        .side     (f_side),
        .out_v    (c_v),
        .cosv     (c_cos),
        .sinv     (c_sin),
        .out_side (c_side)
    );

    ssc_project u_project (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (c_v),
        .cosv    (c_cos),
        .sinv    (c_sin),
        .side    (c_side),
        .rad_lo  (cfg_reg.rad_lo),
        .out_v   (p_v),
        .out_res (p_res)
    );

    assign load = !out_v_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (load)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= p_v;
            end
        end
        else if (adv && p_v)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= skid_v_reg ? skid_reg : p_res;
        end
        else if (adv && p_v)
        begin
            skid_reg <= p_res;
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

endmodule

// ----- rtl/core/ssc_checker.sv -----
// ----------------------------------------------------------------------------
// ssc_checker
// port level checks of the sector scan coordinate generator
// ----------------------------------------------------------------------------
`include "sector_scan_coordinate_generator_defines.svh"

module ssc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input ssc_pkg::ssc_result_t result
);
    import ssc_pkg::*;

    // a result waiting for transfer stays put
    `SSC_ASSERT(a_res_hold, clk, rst_n, result_valid && !result_ready |=> result_valid, "result dropped")
    `SSC_ASSERT(a_res_stable, clk, rst_n, result_valid && !result_ready |=> $stable(result), "result changed while stalled")

    // out of range indices give a zero point
    `SSC_ASSERT(a_err_zero, clk, rst_n, result_valid && result.index_error |-> result.x_coord == '0 && result.y_coord == '0, "flagged result not zero")

    // input only closes when the output holds a result
    `SSC_ASSERT_ALWAYS(a_ready_low, clk, !item_ready |-> result_valid, "input stalled with empty output")

endmodule

bind sector_scan_coordinate_generator ssc_checker u_ssc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ----- tb/sector_scan_coordinate_generator_tb.sv -----
// ----------------------------------------------------------------------------
// sector_scan_coordinate_generator_tb
// self-checking bench for the sector scan coordinate generator
// ----------------------------------------------------------------------------
// Drives (row, column) index pairs through a valid/ready driver fed from a
// queue, predicts each x/y coordinate pair with a local polar to cartesian
// model (cordic in degrees, fixed point), and checks every result in order.
// Several register settings are visited, the extremes among them, with random
// gaps on both sides, a long output stall and full drains between phases.
module sector_scan_coordinate_generator_tb;
    import ssc_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  STALL_LIMIT = 3000;
    localparam int  LONG_HOLD   = 300;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    localparam longint ATAN_Q16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    ssc_item_t              item;
    logic                   result_valid;
    logic                   result_ready;
    ssc_result_t            result;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ssc_cfg_t               geom;
    ssc_item_t              pixel_q[$];
    ssc_result_t            coord_q[$];
    int                     mismatches;
    int                     tx_wait;
    int                     rx_wait;
    int                     long_hold;
    int                     stall_cycles;
    int                     n_items;
    int                     n_errors_seen;
    bit                     gaps_on;
    bit                     long_req;
    bit                     long_taken;

    sector_scan_coordinate_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic longint clamp_coord(longint v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    function automatic ssc_result_t scan_convert(ssc_item_t px);
        ssc_result_t res;
        longint diff, mag, stepq, base, rq, angq, ang, cx, sy, z, dx, dy;
        bit flip;
        res = '0;
        if (px.row_index >= geom.row_count || px.col_index >= geom.col_count)
        begin
            res.index_error = 1'b1;
            return res;
        end
        diff  = longint'(geom.rad_hi) - longint'(geom.rad_lo);
        mag   = diff < 0 ? -diff : diff;
        stepq = ((longint'(px.row_index) * mag) << FRAC_BITS) / longint'(geom.row_count);
        base  = longint'(geom.rad_lo) << FRAC_BITS;
        rq    = diff < 0 ? base - stepq : base + stepq;
        angq  = ((longint'(px.col_index) * longint'(geom.angle_span)) << 8)
                / longint'(geom.col_count);
        ang   = angq - longint'(geom.angle_span) * 128;
        flip  = 1'b0;
        // fold into +-90 deg, negate both outputs afterwards
        if (ang > (longint'(90) << 16))
        begin
            ang  = ang - (longint'(180) << 16);
            flip = 1'b1;
        end
        else if (ang < -(longint'(90) << 16))
        begin
            ang  = ang + (longint'(180) << 16);
            flip = 1'b1;
        end
        cx = 652032874;
        sy = 0;
        z  = ang;
        for (int i = 0; i < 16; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx;
                sy = sy + dy;
                z  = z - ATAN_Q16[i];
            end
            else
            begin
                cx = cx + dx;
                sy = sy - dy;
                z  = z + ATAN_Q16[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            sy = -sy;
        end
        res.x_coord = COORD_W'(clamp_coord(-((rq * cx + (longint'(1) << 29)) >>> 30) - base));
        res.y_coord = COORD_W'(clamp_coord(-((rq * sy + (longint'(1) << 29)) >>> 30) - base));
        return res;
    endfunction

    // driver: one transfer per handshake, random gap after each when gaps are on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            tx_wait    = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                coord_q.insert(coord_q.size(), scan_convert(item));
                n_items++;
                tx_wait = gaps_on ? $urandom_range(0, 4) : 0;
            end
            if (!(item_valid && !item_ready))
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    item_valid <= 1'b0;
                end
                else if (pixel_q.size() > 0)
                begin
                    item       <= pixel_q.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each transfer out with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        ssc_result_t exp_res;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_wait      = 0;
            long_hold    = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (coord_q.size() == 0)
                begin
                    $error("result with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    exp_res = coord_q.pop_front();
                    if (result.x_coord !== exp_res.x_coord)
                    begin
                        $error("x_coord expected %0d got %0d", exp_res.x_coord,
                               result.x_coord);
                        mismatches++;
                    end
                    if (result.y_coord !== exp_res.y_coord)
                    begin
                        $error("y_coord expected %0d got %0d", exp_res.y_coord,
                               result.y_coord);
                        mismatches++;
                    end
                    if (result.index_error !== exp_res.index_error)
                    begin
                        $error("index_error expected %0b got %0b",
                               exp_res.index_error, result.index_error);
                        mismatches++;
                    end
                    if (exp_res.index_error)
                        n_errors_seen++;
                end
                rx_wait = gaps_on ? $urandom_range(0, 4) : 0;
            end
            if (long_req && !long_taken)
            begin
                long_taken = 1'b1;
                long_hold  = LONG_HOLD;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                result_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_RAD_LO:     geom.rad_lo     = val[RAD_W-1:0];
            REG_RAD_HI:     geom.rad_hi     = val[RAD_W-1:0];
            REG_ANGLE_SPAN: geom.angle_span = val;
            REG_ROW_COUNT:  geom.row_count  = val[CNT_W-1:0];
            REG_COL_COUNT:  geom.col_count  = val[CNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int rmin, int rmax, int span, int rows, int cols);
        write_reg(REG_RAD_LO, CFG_DATA_W'(rmin));
        write_reg(REG_RAD_HI, CFG_DATA_W'(rmax));
        write_reg(REG_ANGLE_SPAN, CFG_DATA_W'(span));
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(rows));
        write_reg(REG_COL_COUNT, CFG_DATA_W'(cols));
    endtask

    task automatic drain;
        while (pixel_q.size() > 0 || item_valid || coord_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_index(int cnt);
        if (cnt == 0 || $urandom_range(0, 4) == 0)
            return IDX_W'($urandom);
        return IDX_W'($urandom_range(0, (cnt > 4096 ? 4096 : cnt) - 1));
    endfunction

    task automatic queue_pixel(int r, int c);
        ssc_item_t px;
        px.row_index = IDX_W'(r);
        px.col_index = IDX_W'(c);
        pixel_q.insert(pixel_q.size(), px);
    endtask

    task automatic queue_random(int n);
        repeat (n)
            queue_pixel(pick_index(geom.row_count), pick_index(geom.col_count));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        gaps_on    = 1'b1;
        long_req   = 1'b0;
        long_taken = 1'b0;
        mismatches = 0;
        n_items    = 0;
        n_errors_seen = 0;
        stall_cycles  = 0;
        geom = '{rad_lo: 1, rad_hi: 300, angle_span: 14080,
                 row_count: 256, col_count: 256};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: edges of both indices and the out of range cases
        queue_pixel(0, 0);
        queue_pixel(255, 255);
        queue_pixel(0, 255);
        queue_pixel(255, 0);
        queue_pixel(128, 128);
        queue_pixel(256, 0);
        queue_pixel(0, 256);
        queue_pixel(4095, 4095);
        queue_pixel(12'haaa, 12'h555);
        queue_pixel(12'h555, 12'haaa);
        queue_random(140);
        drain();

        // extremes: a 180 deg span, full size image, long stall
        set_geometry(0, 1023, 46080, 4096, 4096);
        write_reg(REG_NONE_LO, 16'hffff);
        write_reg(REG_NONE_HI, 16'h0000);
        queue_pixel(4095, 0);
        queue_pixel(4095, 4095);
        queue_pixel(0, 2048);
        queue_pixel(4095, 2048);
        long_req = 1'b1;
        queue_random(150);
        drain();

        // radius stepping downward, zero span, single pixel image
        set_geometry(1023, 0, 0, 1, 1);
        queue_pixel(0, 0);
        queue_pixel(1, 0);
        queue_pixel(0, 1);
        queue_random(40);
        drain();

        // full 16 bit span, count above the index range, odd column count
        set_geometry(500, 200, 65535, 8191, 37);
        gaps_on = 1'b0;
        queue_pixel(4095, 36);
        queue_pixel(4095, 0);
        queue_random(150);
        drain();
        gaps_on = 1'b1;

        // zero column count flags every index
        set_geometry(1023, 1023, 23040, 4096, 0);
        queue_random(30);
        drain();

        repeat (6)
        begin
            set_geometry($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 46080), $urandom_range(1, 4096),
                         $urandom_range(1, 4096));
            gaps_on = $urandom_range(0, 3) != 0;
            queue_random(70);
            // sender holds back until everything so far has come out
            while (pixel_q.size() > 0 || item_valid || coord_q.size() > 0)
                @(posedge clk);
            queue_random(70);
            drain();
        end

        if (coord_q.size() > 0)
        begin
            $error("%0d predictions never matched by a result", coord_q.size());
            mismatches++;
        end
        $display("covered %0d index pairs over 11 geometries, %0d flagged out of range",
                 n_items, n_errors_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
